// ===== sv/assert_macros.svh =====
// Assertion macros used by the PM/0 instruction executor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== sv/pm0_pkg.sv =====
// Package: opcodes, fault codes, SIO codes, sizes and divider types for the PM/0 machine.
package pm0_pkg;
  localparam int StackDepthDef = 2048;
  localparam int MaxLevelsDef  = 3;

  typedef enum logic [4:0] {
    OP_LIT = 5'd1, OP_RTN = 5'd2, OP_LOD = 5'd3, OP_STO = 5'd4, OP_CAL = 5'd5,
    OP_INC = 5'd6, OP_JMP = 5'd7, OP_JPC = 5'd8, OP_SIO = 5'd9, OP_NEG = 5'd10,
    OP_ADD = 5'd11, OP_SUB = 5'd12, OP_MUL = 5'd13, OP_DIV = 5'd14,
    OP_ODD = 5'd15, OP_MOD = 5'd16, OP_EQL = 5'd17, OP_NEQ = 5'd18,
    OP_LSS = 5'd19, OP_LEQ = 5'd20, OP_GTR = 5'd21, OP_GEQ = 5'd22
  } op_t;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_DIV0  = 2'd1;
  localparam logic [1:0] FLT_RANGE = 2'd2;
  localparam logic [1:0] FLT_OP    = 2'd3;

  localparam logic [31:0] SIO_WRITE = 32'd1;
  localparam logic [31:0] SIO_READ  = 32'd2;
  localparam logic [31:0] SIO_HALT  = 32'd3;

  localparam int DivSteps = 32;

  // divider request / answer between the core and the divide unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

// ===== sv/pm0_div.sv =====
// Iterative signed divider, one quotient bit per cycle while busy; a start while busy is ignored.
module pm0_div
  import pm0_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [31:0] a_mag, b_mag, q, rem_acc;
  logic        neg_q, neg_r, busy, done;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem_acc, q[31]} - {1'b0, b_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        a_mag <= req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
        b_mag <= req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
        neg_q <= req.dividend[31] ^ req.divisor[31];
        neg_r <= req.dividend[31];
        cnt <= 6'(DivSteps);
        rem_acc <= '0;
      end else if (busy) begin
        if (cnt == 6'(DivSteps)) begin
          q <= a_mag;
          cnt <= cnt - 6'd1;
        end else begin
          if (!trial[32]) begin
            rem_acc <= trial[31:0];
            q <= {q[30:0], 1'b1};
          end else begin
            rem_acc <= {rem_acc[30:0], q[31]};
            q <= {q[30:0], 1'b0};
          end
          if (cnt == 6'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quot = neg_q ? 32'd0 - q : q;
    rsp.rem  = neg_r ? 32'd0 - rem_acc : rem_acc;
  end
endmodule

// ===== sv/pm0_register_stack_machine.sv =====
// PM/0 instruction executor: one instruction per input beat, one result beat each.
// States per beat: DECODE, EXEC, OUT; RTN adds RTN_WT, DIV/MOD add DIV_WT, LOD adds MEM_WT,
// CAL adds CAL_WR; LOD, STO and CAL first walk the static link (WALK_RD, WALK_WT per level).
// One instruction in flight; s_tready returns the cycle after the result beat is taken.
// After reset the stack memory is swept to zero in S_CLEAR; no input is taken until it ends.
// rst is synchronous, active high; clears pc, sp, halt, registers; bp to 1.
`include "assert_macros.svh"
module pm0_register_stack_machine
  import pm0_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int MAX_LEVELS  = MaxLevelsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,  // op[4:0], reg_index[7:5], level[11:8], operand[43:12], read_value[75:44]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata   // next_pc, base_ptr, stack_ptr, reg_value, out_valid, out_value, halted, fault[2]
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(MAX_LEVELS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_WALK_RD, S_WALK_WT, S_EXEC, S_MEM_WT,
    S_CAL_WR, S_RTN_WT, S_DIV_WT, S_OUT
  } state_t;

  state_t state;
  // stack memory, one read and one write port
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] mem_rdata;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;
  logic [AW-1:0] clr_cnt;

  logic [31:0] regs [8];
  logic [31:0] pc, bp, sp;
  logic        halt;

  logic [4:0]  op;
  logic [2:0]  ri;
  logic [3:0]  lv;
  logic [31:0] m_op, rd_val, base_cur;
  logic [LW-1:0] walk_left;
  logic [1:0]  cal_idx;
  logic [31:0] rtn_pc;
  logic        rtn_phase;

  logic [31:0] o_pc, o_bp, o_sp, o_reg, o_val;
  logic        o_ovalid, o_halt;
  logic [1:0]  o_fault;

  div_req_t dreq;
  div_rsp_t drsp;

  pm0_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_rdata <= mem[rd_addr];
  end

  // in-range test on a signed 34-bit address
  function automatic logic ok(input logic signed [33:0] a);
    return (a >= 0) && (a < 34'(STACK_DEPTH));
  endfunction

  logic signed [33:0] eff;
  logic [31:0] rj, rk, sum8;
  logic [63:0] prod;
  assign eff = $signed({{2{base_cur[31]}}, base_cur}) + $signed({{2{m_op[31]}}, m_op});
  assign rj = regs[lv[2:0]];
  assign rk = regs[m_op[2:0]];
  assign prod = rj * rk;
  always_comb begin
    sum8 = '0;
    for (int k = 0; k < 8; k++) sum8 = sum8 + regs[k];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {4'd0, o_fault, o_halt, o_val, o_ovalid, o_reg, o_sp, o_bp, o_pc};

  always_comb begin
    dreq.start = (state == S_EXEC) && (op == OP_DIV || op == OP_MOD) && rk != 0;
    dreq.dividend = rj;
    dreq.divisor = rk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      pc <= '0; bp <= 32'd1; sp <= '0; halt <= 1'b0;
      for (int k = 0; k < 8; k++) regs[k] <= '0;
      wr_en <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          wr_en <= 1'b1; wr_addr <= clr_cnt; wr_data <= '0;
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(STACK_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tdata[4:0]; ri <= s_tdata[7:5]; lv <= s_tdata[11:8];
            m_op <= s_tdata[43:12]; rd_val <= s_tdata[75:44];
            base_cur <= bp;
            walk_left <= (s_tdata[11:8] > 4'(MAX_LEVELS)) ? LW'(MAX_LEVELS)
                                                          : LW'(s_tdata[11:8]);
            o_ovalid <= 1'b0; o_val <= '0; o_fault <= FLT_NONE;
            cal_idx <= '0; rtn_phase <= 1'b0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (halt) state <= S_OUT;
          else if ((op == OP_LOD || op == OP_STO || op == OP_CAL) && walk_left != 0)
            state <= S_WALK_RD;
          else state <= S_EXEC;
        end
        S_WALK_RD: begin
          if (!ok($signed({{2{base_cur[31]}}, base_cur}) + 34'sd1)) begin
            o_fault <= FLT_RANGE; state <= S_OUT;
          end else begin
            rd_addr <= AW'(base_cur + 32'd1);
            state <= S_WALK_WT;
          end
        end
        S_WALK_WT: begin
          // wait state that lets the registered read land
          if (rtn_phase) begin
            base_cur <= mem_rdata;
            rtn_phase <= 1'b0;
            walk_left <= walk_left - LW'(1);
            state <= (walk_left == LW'(1)) ? S_EXEC : S_WALK_RD;
          end else rtn_phase <= 1'b1;
        end
        S_EXEC: begin
          state <= S_OUT;
          unique case (op)
            OP_LIT: begin regs[ri] <= m_op; pc <= pc + 1; end
            OP_RTN: begin
              if (!ok($signed({{2{bp[31]}}, bp}) + 34'sd2) ||
                  !ok($signed({{2{bp[31]}}, bp}) + 34'sd3)) o_fault <= FLT_RANGE;
              else begin rd_addr <= AW'(bp + 32'd3); state <= S_RTN_WT; end
            end
            OP_LOD, OP_STO: begin
              if (!ok(eff)) o_fault <= FLT_RANGE;
              else if (op == OP_STO) begin
                wr_en <= 1'b1; wr_addr <= AW'(eff); wr_data <= regs[ri];
                pc <= pc + 1;
              end else begin rd_addr <= AW'(eff); state <= S_MEM_WT; end
            end
            OP_CAL: begin
              if (!ok($signed({{2{sp[31]}}, sp}) + 34'sd1) ||
                  !ok($signed({{2{sp[31]}}, sp}) + 34'sd4)) o_fault <= FLT_RANGE;
              else state <= S_CAL_WR;
            end
            OP_INC: begin sp <= sp + m_op; pc <= pc + 1; end
            OP_JMP: pc <= m_op;
            OP_JPC: pc <= (regs[ri] == 0) ? m_op : pc + 1;
            OP_SIO: begin
              if (m_op == SIO_WRITE) begin
                o_ovalid <= 1'b1; o_val <= regs[ri]; pc <= pc + 1;
              end else if (m_op == SIO_READ) begin
                regs[ri] <= rd_val; pc <= pc + 1;
              end else if (m_op == SIO_HALT) begin
                o_ovalid <= 1'b1; o_val <= sum8; halt <= 1'b1; pc <= pc + 1;
              end else o_fault <= FLT_OP;
            end
            OP_NEG: begin regs[ri] <= 32'd0 - rj; pc <= pc + 1; end
            OP_ADD: begin regs[ri] <= rj + rk; pc <= pc + 1; end
            OP_SUB: begin regs[ri] <= rj - rk; pc <= pc + 1; end
            OP_MUL: begin regs[ri] <= prod[31:0]; pc <= pc + 1; end
            OP_DIV, OP_MOD: begin
              if (rk == 0) o_fault <= FLT_DIV0;
              else state <= S_DIV_WT;
            end
            OP_ODD: begin regs[ri] <= regs[ri] & 32'd1; pc <= pc + 1; end
            OP_EQL: begin regs[ri] <= 32'(rj == rk); pc <= pc + 1; end
            OP_NEQ: begin regs[ri] <= 32'(rj != rk); pc <= pc + 1; end
            OP_LSS: begin regs[ri] <= 32'($signed(rj) < $signed(rk)); pc <= pc + 1; end
            OP_LEQ: begin regs[ri] <= 32'($signed(rj) <= $signed(rk)); pc <= pc + 1; end
            OP_GTR: begin regs[ri] <= 32'($signed(rj) > $signed(rk)); pc <= pc + 1; end
            OP_GEQ: begin regs[ri] <= 32'($signed(rj) >= $signed(rk)); pc <= pc + 1; end
            default: o_fault <= FLT_OP;
          endcase
        end
        S_MEM_WT: begin
          if (rtn_phase) begin
            regs[ri] <= mem_rdata; pc <= pc + 1; state <= S_OUT;
          end else rtn_phase <= 1'b1;
        end
        S_CAL_WR: begin
          // frame words: 0, static link, dynamic link, return pc
          wr_en <= 1'b1;
          wr_addr <= AW'(sp + 32'd1 + 32'(cal_idx));
          unique case (cal_idx)
            2'd0: wr_data <= '0;
            2'd1: wr_data <= base_cur;
            2'd2: wr_data <= bp;
            default: wr_data <= pc + 1;
          endcase
          cal_idx <= cal_idx + 2'd1;
          if (cal_idx == 2'd3) begin
            bp <= sp + 1; pc <= m_op; state <= S_OUT;
          end
        end
        S_RTN_WT: begin
          // cycle A: issue bp+2 read; B: pc word lands; C: bp word lands
          if (!rtn_phase) begin
            rtn_phase <= 1'b1; rd_addr <= AW'(bp + 32'd2); walk_left <= '0;
          end else if (walk_left == '0) begin
            rtn_pc <= mem_rdata; walk_left <= LW'(1);
          end else begin
            sp <= bp - 1; pc <= rtn_pc; bp <= mem_rdata; state <= S_OUT;
          end
        end
        S_DIV_WT: begin
          if (drsp.done) begin
            regs[ri] <= (op == OP_DIV) ? drsp.quot : drsp.rem;
            pc <= pc + 1; state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result fields follow the state except where captured above
  always_comb begin
    o_pc = pc; o_bp = bp; o_sp = sp; o_reg = regs[ri]; o_halt = halt;
  end

  `ASSERT_IMPLIES(a_no_both, clk, rst, m_tvalid, !s_tready)
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(pc))
  `ASSERT_IMPLIES(a_fault_quiet, clk, rst, m_tvalid && o_fault != FLT_NONE, !o_ovalid)
endmodule
